>>> rtl/mmq_pkg.sv
`timescale 1ns / 1ps

package mmq_pkg;

  localparam int GROUP_ROWS       = 128;
  localparam int CODES_PER_RESULT = 4;
  localparam int ROW_W            = $clog2(GROUP_ROWS);
  localparam int NIB_W            = (CODES_PER_RESULT > 1) ? $clog2(CODES_PER_RESULT) : 1;
  localparam int QUAD_W           = 16;
  localparam int QDIV_BITS        = 26;
  localparam int CNT_W            = $clog2(QDIV_BITS);

  localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
  localparam logic [31:0] FP_FIFTEEN  = 32'h4170_0000;
  localparam logic [31:0] FP_POS_1E30 = 32'h7149_F2CA;
  localparam logic [31:0] FP_NEG_1E30 = 32'hF149_F2CA;
  localparam logic [31:0] FP_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] BF16_BIAS   = 32'h0000_7FFF;

  localparam logic signed [9:0] ZP_MIN   = -10'sd128;
  localparam logic signed [9:0] ZP_MAX   = 10'sd127;
  localparam logic signed [9:0] CODE_MIN = 10'sd0;
  localparam logic signed [9:0] CODE_MAX = 10'sd15;

  typedef enum logic [9:0] {
    S_LOAD      = 10'b00_0000_0001,
    S_SUB1      = 10'b00_0000_0010,
    S_SUB2      = 10'b00_0000_0100,
    S_MEM_RD    = 10'b00_0000_1000,
    S_DIV_INIT  = 10'b00_0001_0000,
    S_DIV_NORM  = 10'b00_0010_0000,
    S_DIV_ITER  = 10'b00_0100_0000,
    S_DIV_SHIFT = 10'b00_1000_0000,
    S_DIV_ROUND = 10'b01_0000_0000,
    S_EMIT      = 10'b10_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    PH_SCALE = 2'd0,
    PH_ZP    = 2'd1,
    PH_CODE  = 2'd2
  } phase_t;

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        inf_sign;
    logic        zero_sign;
    logic        sign;
    logic [7:0]  exp;
    logic [27:0] sum;
  } add_s1_t;

  function automatic logic fp_is_nan(input logic [31:0] x);
    return (&x[30:23]) && (|x[22:0]);
  endfunction

  function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
    logic nan;
    logic both_zero;
    logic r;
    nan       = fp_is_nan(a) || fp_is_nan(b);
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    if (nan || both_zero) begin
      r = 1'b0;
    end else if (a[31] != b[31]) begin
      r = a[31];
    end else if (!a[31]) begin
      r = a[30:0] < b[30:0];
    end else begin
      r = a[30:0] > b[30:0];
    end
    return r;
  endfunction

  // align and add
  function automatic add_s1_t fp_add_s1(input logic [31:0] a, input logic [31:0] b);
    logic        a_nan, b_nan, a_inf, b_inf, swap, stk;
    logic [31:0] big, sml;
    logic [7:0]  eg, es, d;
    logic [26:0] mg, ms, msh;
    add_s1_t     r;
    a_nan = fp_is_nan(a);
    b_nan = fp_is_nan(b);
    a_inf = (&a[30:23]) && (a[22:0] == 23'd0);
    b_inf = (&b[30:23]) && (b[22:0] == 23'd0);
    r.nan       = a_nan || b_nan || (a_inf && b_inf && (a[31] ^ b[31]));
    r.inf       = a_inf || b_inf;
    r.inf_sign  = a_inf ? a[31] : b[31];
    r.zero_sign = a[31] & b[31];
    swap = a[30:0] < b[30:0];
    big  = swap ? b : a;
    sml  = swap ? a : b;
    eg   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mg   = {|big[30:23], big[22:0], 3'b000};
    ms   = {|sml[30:23], sml[22:0], 3'b000};
    d    = eg - es;
    if (d >= 8'd27) begin
      msh = '0;
      stk = |ms;
    end else begin
      msh = ms >> d;
      stk = |(ms & ~({27{1'b1}} << d));
    end
    msh[0] = msh[0] | stk;
    if (big[31] == sml[31]) begin
      r.sum = {1'b0, mg} + {1'b0, msh};
    end else begin
      r.sum = {1'b0, mg} - {1'b0, msh};
    end
    r.sign = big[31];
    r.exp  = eg;
    return r;
  endfunction

  // normalize and round to nearest even
  function automatic logic [31:0] fp_add_s2(input add_s1_t s);
    logic [4:0]  lz, sh;
    logic [9:0]  e, lim, ef;
    logic [26:0] m;
    logic [24:0] mr;
    logic        up;
    logic [31:0] r;
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (s.sum[i]) begin
        lz = 5'(26 - i);
      end
    end
    e = {2'b00, s.exp};
    if (s.sum[27]) begin
      m = {s.sum[27:2], s.sum[1] | s.sum[0]};
      e = e + 10'd1;
    end else begin
      lim = e - 10'd1;
      sh  = ({5'b0, lz} > lim) ? lim[4:0] : lz;
      m   = s.sum[26:0] << sh;
      e   = e - {5'b0, sh};
    end
    up = m[2] & (m[1] | m[0] | m[3]);
    mr = {1'b0, m[26:3]} + {24'b0, up};
    ef = mr[24] ? (e + 10'd1) : (mr[23] ? e : 10'd0);
    if (s.nan) begin
      r = FP_QNAN;
    end else if (s.inf) begin
      r = {s.inf_sign, 8'hFF, 23'd0};
    end else if (s.sum == 28'd0) begin
      r = {s.zero_sign, 31'd0};
    end else if (ef >= 10'd255) begin
      r = {s.sign, 8'hFF, 23'd0};
    end else begin
      r = {s.sign, ef[7:0], mr[22:0]};
    end
    return r;
  endfunction

  // round half away from zero, saturate, NaN gives zero
  function automatic logic signed [9:0] fp_round_sat(input logic [31:0] x,
                                                      input logic signed [9:0] lo,
                                                      input logic signed [9:0] hi);
    logic [7:0]         ex;
    logic [23:0]        mt;
    logic [8:0]         rr;
    logic [9:0]         mag;
    logic signed [9:0]  v;
    logic signed [9:0]  res;
    ex = x[30:23];
    mt = {1'b1, x[22:0]};
    v  = 10'sd0;
    if (fp_is_nan(x)) begin
      res = 10'sd0;
    end else if (ex >= 8'd135) begin
      res = x[31] ? lo : hi;
    end else begin
      if (ex >= 8'd126) begin
        rr  = 9'(mt >> (8'd149 - ex));
        mag = ({1'b0, rr} + 10'd1) >> 1;
        v   = x[31] ? $signed(10'd0 - mag) : $signed(mag);
      end
      if (v < lo) begin
        res = lo;
      end else if (v > hi) begin
        res = hi;
      end else begin
        res = v;
      end
    end
    return res;
  endfunction

  function automatic logic [15:0] fp_to_bf16(input logic [31:0] x);
    logic [31:0] t;
    t = x + BF16_BIAS + {31'd0, x[16]};
    return t[31:16];
  endfunction

endpackage

>>> rtl/minmax_int4_group_quantizer_unit.sv
`timescale 1ns / 1ps

// Takes one fp32 weight per transaction, one per cycle, until a group of 128 is
// stored; in_ready then drops while the group is quantized. The scale and zero
// point cost one subtract and two divisions up front, then every code costs
// a buffer read, an fp32 subtract split into align and normalize states and a
// restoring divider that retires one quotient bit per cycle over 26 steps,
// plus extra normalize or shift steps for subnormal operands or quotients. One
// result transaction carries four codes, the bf16 scale and the zero point;
// group_end marks the last of the 32 results. A stalled result holds the
// sequencer; the input reopens once the last result of the group is issued.
module minmax_int4_group_quantizer_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [31:0]               in_sample_bits,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mmq_pkg::QUAD_W-1:0] out_code_quad,
  output logic [15:0]               out_scale_bf16,
  output logic signed [7:0]         out_zero_point,
  output logic                      out_group_end
);

  mmq_pkg::state_t  state_r;
  mmq_pkg::phase_t  phase_r;
  mmq_pkg::add_s1_t s1_r;
  mmq_pkg::add_s1_t s1_c;

  logic [mmq_pkg::ROW_W-1:0]  fill_r;
  logic [mmq_pkg::ROW_W-1:0]  row_r;
  logic [mmq_pkg::NIB_W-1:0]  nib_r;
  logic [31:0]                min_r;
  logic [31:0]                max_r;
  logic [31:0]                mem [mmq_pkg::GROUP_ROWS];
  logic [31:0]                mem_q_r;
  logic [31:0]                diff_r;
  logic [31:0]                scale_r;
  logic [7:0]                 zp_r;
  logic [mmq_pkg::QUAD_W-1:0] quad_r;

  logic                           div_sign_r;
  logic                           div_nan_r;
  logic                           sticky_r;
  logic signed [10:0]             div_exp_r;
  logic [23:0]                    na_r;
  logic [23:0]                    nb_r;
  logic [24:0]                    rem_r;
  logic [mmq_pkg::QDIV_BITS-1:0]  q_r;
  logic [mmq_pkg::CNT_W-1:0]      cnt_r;

  logic                      out_valid_r;
  logic [mmq_pkg::QUAD_W-1:0] out_quad_r;
  logic [15:0]               out_scale_r;
  logic signed [7:0]         out_zp_r;
  logic                      out_end_r;

  logic               in_accept;
  logic               out_take;
  logic               last_row;
  logic [31:0]        neg_min;
  logic [31:0]        add_a;
  logic [31:0]        add_res;
  logic [31:0]        div_num;
  logic [31:0]        div_den;
  logic               a_e0, b_e0, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic               di_nan, di_inf, di_zero;
  logic signed [10:0] di_exp;
  logic               rem_ge;
  logic [24:0]        rem_diff;
  logic [24:0]        rem_nxt;
  logic               rnd_up;
  logic [24:0]        mr;
  logic signed [10:0] ef;
  logic [31:0]        div_res;
  logic signed [9:0]  rs_lo;
  logic signed [9:0]  rs_hi;
  logic signed [9:0]  div_int;
  logic [31:0]        scale_fb;

  assign in_ready  = (state_r == mmq_pkg::S_LOAD);
  assign in_accept = in_valid & in_ready;
  assign out_take  = !out_valid_r || out_ready;
  assign last_row  = (row_r == mmq_pkg::ROW_W'(mmq_pkg::GROUP_ROWS - 1));

  assign out_valid      = out_valid_r;
  assign out_code_quad  = out_quad_r;
  assign out_scale_bf16 = out_scale_r;
  assign out_zero_point = out_zp_r;
  assign out_group_end  = out_end_r;

  assign neg_min = {~min_r[31], min_r[30:0]};
  assign add_a   = (phase_r == mmq_pkg::PH_SCALE) ? max_r : mem_q_r;
  assign s1_c    = mmq_pkg::fp_add_s1(add_a, neg_min);
  assign add_res = mmq_pkg::fp_add_s2(s1_r);

  always_comb begin
    unique case (phase_r)
      mmq_pkg::PH_SCALE: begin
        div_num = diff_r;
        div_den = mmq_pkg::FP_FIFTEEN;
      end
      mmq_pkg::PH_ZP: begin
        div_num = neg_min;
        div_den = scale_r;
      end
      default: begin
        div_num = diff_r;
        div_den = scale_r;
      end
    endcase
  end

  always_comb begin
    a_e0    = (div_num[30:23] == 8'd0);
    b_e0    = (div_den[30:23] == 8'd0);
    a_nan   = mmq_pkg::fp_is_nan(div_num);
    b_nan   = mmq_pkg::fp_is_nan(div_den);
    a_inf   = (&div_num[30:23]) && (div_num[22:0] == 23'd0);
    b_inf   = (&div_den[30:23]) && (div_den[22:0] == 23'd0);
    a_zero  = (div_num[30:0] == 31'd0);
    b_zero  = (div_den[30:0] == 31'd0);
    di_nan  = a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero);
    di_inf  = a_inf || b_zero;
    di_zero = a_zero || b_inf;
    di_exp  = $signed({3'b000, a_e0 ? 8'd1 : div_num[30:23]})
            - $signed({3'b000, b_e0 ? 8'd1 : div_den[30:23]}) + 11'sd127;
  end

  assign rem_ge   = (rem_r >= {1'b0, nb_r});
  assign rem_diff = rem_r - {1'b0, nb_r};
  assign rem_nxt  = rem_ge ? {rem_diff[23:0], 1'b0} : {rem_r[23:0], 1'b0};

  always_comb begin
    rnd_up = q_r[1] & (q_r[0] | sticky_r | q_r[2]);
    mr     = {1'b0, q_r[25:2]} + {24'd0, rnd_up};
    ef     = mr[24] ? (div_exp_r + 11'sd1) : (mr[23] ? div_exp_r : 11'sd0);
    if (div_nan_r) begin
      div_res = mmq_pkg::FP_QNAN;
    end else if (ef >= 11'sd255) begin
      div_res = {div_sign_r, 8'hFF, 23'd0};
    end else begin
      div_res = {div_sign_r, ef[7:0], mr[22:0]};
    end
  end

  assign rs_lo   = (phase_r == mmq_pkg::PH_ZP) ? mmq_pkg::ZP_MIN : mmq_pkg::CODE_MIN;
  assign rs_hi   = (phase_r == mmq_pkg::PH_ZP) ? mmq_pkg::ZP_MAX : mmq_pkg::CODE_MAX;
  assign div_int = mmq_pkg::fp_round_sat(div_res, rs_lo, rs_hi);

  assign scale_fb = (div_res[30:0] != 31'd0) ? div_res :
                    (min_r[30:0] == 31'd0) ? mmq_pkg::FP_ONE : {1'b0, min_r[30:0]};

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mem[fill_r] <= in_sample_bits;
    end
    if (state_r == mmq_pkg::S_MEM_RD) begin
      mem_q_r <= mem[row_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmq_pkg::S_LOAD;
      phase_r     <= mmq_pkg::PH_SCALE;
      fill_r      <= '0;
      min_r       <= mmq_pkg::FP_POS_1E30;
      max_r       <= mmq_pkg::FP_NEG_1E30;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != mmq_pkg::S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        mmq_pkg::S_LOAD: begin
          if (in_accept) begin
            if (mmq_pkg::fp_lt(in_sample_bits, min_r)) begin
              min_r <= in_sample_bits;
            end
            if (mmq_pkg::fp_lt(max_r, in_sample_bits)) begin
              max_r <= in_sample_bits;
            end
            if (fill_r == mmq_pkg::ROW_W'(mmq_pkg::GROUP_ROWS - 1)) begin
              fill_r  <= '0;
              phase_r <= mmq_pkg::PH_SCALE;
              state_r <= mmq_pkg::S_SUB1;
            end else begin
              fill_r <= fill_r + 1'b1;
            end
          end
        end
        mmq_pkg::S_SUB1: begin
          s1_r    <= s1_c;
          state_r <= mmq_pkg::S_SUB2;
        end
        mmq_pkg::S_SUB2: begin
          diff_r  <= add_res;
          state_r <= mmq_pkg::S_DIV_INIT;
        end
        mmq_pkg::S_MEM_RD: begin
          state_r <= mmq_pkg::S_SUB1;
        end
        mmq_pkg::S_DIV_INIT: begin
          div_sign_r <= div_num[31] ^ div_den[31];
          div_nan_r  <= di_nan;
          sticky_r   <= 1'b0;
          if (di_nan || di_inf || di_zero) begin
            if (di_inf) begin
              div_exp_r <= 11'sd255;
              q_r       <= {1'b1, {(mmq_pkg::QDIV_BITS - 1){1'b0}}};
            end else begin
              div_exp_r <= 11'sd1;
              q_r       <= '0;
            end
            state_r <= mmq_pkg::S_DIV_ROUND;
          end else begin
            na_r      <= {~a_e0, div_num[22:0]};
            nb_r      <= {~b_e0, div_den[22:0]};
            div_exp_r <= di_exp;
            state_r   <= mmq_pkg::S_DIV_NORM;
          end
        end
        mmq_pkg::S_DIV_NORM: begin
          if (na_r[23] && nb_r[23]) begin
            if (na_r < nb_r) begin
              rem_r     <= {na_r, 1'b0};
              div_exp_r <= div_exp_r - 11'sd1;
            end else begin
              rem_r <= {1'b0, na_r};
            end
            cnt_r   <= '0;
            q_r     <= '0;
            state_r <= mmq_pkg::S_DIV_ITER;
          end else begin
            if (!na_r[23]) begin
              na_r <= {na_r[22:0], 1'b0};
            end
            if (!nb_r[23]) begin
              nb_r <= {nb_r[22:0], 1'b0};
            end
            case ({na_r[23], nb_r[23]})
              2'b01:   div_exp_r <= div_exp_r - 11'sd1;
              2'b10:   div_exp_r <= div_exp_r + 11'sd1;
              default: div_exp_r <= div_exp_r;
            endcase
          end
        end
        mmq_pkg::S_DIV_ITER: begin
          rem_r <= rem_nxt;
          q_r   <= {q_r[mmq_pkg::QDIV_BITS-2:0], rem_ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == mmq_pkg::CNT_W'(mmq_pkg::QDIV_BITS - 1)) begin
            sticky_r <= (rem_nxt != 25'd0);
            state_r  <= mmq_pkg::S_DIV_SHIFT;
          end
        end
        mmq_pkg::S_DIV_SHIFT: begin
          if (div_exp_r >= 11'sd1) begin
            state_r <= mmq_pkg::S_DIV_ROUND;
          end else if (div_exp_r < -11'sd26) begin
            q_r       <= '0;
            sticky_r  <= sticky_r | (q_r != '0);
            div_exp_r <= 11'sd1;
            state_r   <= mmq_pkg::S_DIV_ROUND;
          end else begin
            q_r       <= q_r >> 1;
            sticky_r  <= sticky_r | q_r[0];
            div_exp_r <= div_exp_r + 11'sd1;
          end
        end
        mmq_pkg::S_DIV_ROUND: begin
          unique case (phase_r)
            mmq_pkg::PH_SCALE: begin
              scale_r <= scale_fb;
              phase_r <= mmq_pkg::PH_ZP;
              state_r <= mmq_pkg::S_DIV_INIT;
            end
            mmq_pkg::PH_ZP: begin
              zp_r    <= div_int[7:0];
              phase_r <= mmq_pkg::PH_CODE;
              row_r   <= '0;
              nib_r   <= '0;
              quad_r  <= '0;
              state_r <= mmq_pkg::S_MEM_RD;
            end
            default: begin
              quad_r[{nib_r, 2'b00} +: 4] <= div_int[3:0];
              if (nib_r == mmq_pkg::NIB_W'(mmq_pkg::CODES_PER_RESULT - 1) || last_row) begin
                state_r <= mmq_pkg::S_EMIT;
              end else begin
                nib_r   <= nib_r + 1'b1;
                row_r   <= row_r + 1'b1;
                state_r <= mmq_pkg::S_MEM_RD;
              end
            end
          endcase
        end
        mmq_pkg::S_EMIT: begin
          if (out_take) begin
            out_valid_r <= 1'b1;
            out_quad_r  <= quad_r;
            out_scale_r <= mmq_pkg::fp_to_bf16(scale_r);
            out_zp_r    <= $signed(zp_r);
            out_end_r   <= last_row;
            quad_r      <= '0;
            nib_r       <= '0;
            if (last_row) begin
              min_r   <= mmq_pkg::FP_POS_1E30;
              max_r   <= mmq_pkg::FP_NEG_1E30;
              state_r <= mmq_pkg::S_LOAD;
            end else begin
              row_r   <= row_r + 1'b1;
              state_r <= mmq_pkg::S_MEM_RD;
            end
          end
        end
        default: begin
          state_r <= mmq_pkg::S_LOAD;
        end
      endcase
    end
  end

  a_div_norm: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mmq_pkg::S_DIV_ITER |-> nb_r[23] && (rem_r < {nb_r, 1'b0}))
    else $error("divider remainder out of range");

  a_div_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mmq_pkg::S_DIV_ITER && cnt_r == mmq_pkg::CNT_W'(mmq_pkg::QDIV_BITS - 1))
    |=> q_r[mmq_pkg::QDIV_BITS-1])
    else $error("quotient lacks leading one");

  a_group_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mmq_pkg::S_LOAD ##1 state_r != mmq_pkg::S_LOAD |-> fill_r == '0)
    else $error("group left before buffer full");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mmq_pkg::S_EMIT && out_valid_r && !out_ready) |=> state_r == mmq_pkg::S_EMIT)
    else $error("sequencer advanced over a stalled result");

endmodule
